// File: design/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Types, character codes, operator codes and precedence lookup shared by the
// infix expression evaluator and its arithmetic unit.
// ----------------------------------------------------------------------------
package iee_pkg;

  // character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_CARET = 8'd94;
  localparam logic [7:0] CH_LPAR  = 8'd40;
  localparam logic [7:0] CH_RPAR  = 8'd41;

  // operator stack codes
  typedef logic [2:0] opc_t;
  localparam opc_t OPC_ADD  = 3'd0;
  localparam opc_t OPC_SUB  = 3'd1;
  localparam opc_t OPC_MUL  = 3'd2;
  localparam opc_t OPC_DIV  = 3'd3;
  localparam opc_t OPC_MOD  = 3'd4;
  localparam opc_t OPC_POW  = 3'd5;
  localparam opc_t OPC_LPAR = 3'd6;
  localparam opc_t OPC_MARK = 3'd7;

  typedef enum logic [2:0] {
    CL_ADD, CL_MUL, CL_EXP, CL_LPAR, CL_RPAR, CL_END
  } cls_e;

  typedef enum logic [1:0] {
    PR_PUSH, PR_POP, PR_REDUCE, PR_ERR
  } prec_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SYNTAX  = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  typedef enum logic {
    ALU_MUL, ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_RDOP, S_RED, S_MUL, S_DIV,
    S_PW_CHK, S_PW_MR, S_PW_MQ, S_EMIT
  } state_e;

  typedef struct packed {
    logic is_op;
    logic is_rpar;
    opc_t code;
  } chr_t;

  // operator decode of one character
  function automatic chr_t char_decode(logic [7:0] c);
    chr_t r;
    r = '{is_op: 1'b1, is_rpar: 1'b0, code: OPC_ADD};
    case (c)
      CH_PLUS:  r.code = OPC_ADD;
      CH_MINUS: r.code = OPC_SUB;
      CH_STAR:  r.code = OPC_MUL;
      CH_SLASH: r.code = OPC_DIV;
      CH_PCT:   r.code = OPC_MOD;
      CH_CARET: r.code = OPC_POW;
      CH_LPAR:  r.code = OPC_LPAR;
      CH_RPAR:  begin
        r.is_op   = 1'b0;
        r.is_rpar = 1'b1;
      end
      default:  r.is_op = 1'b0;
    endcase
    return r;
  endfunction

  // precedence class of a stacked operator
  function automatic cls_e op_class(opc_t t);
    cls_e r;
    unique case (t)
      OPC_ADD, OPC_SUB: r = CL_ADD;
      OPC_MUL, OPC_DIV: r = CL_MUL;
      OPC_MOD, OPC_POW: r = CL_EXP;
      OPC_LPAR:         r = CL_LPAR;
      default:          r = CL_END;
    endcase
    return r;
  endfunction

  // rows: class on top of the stack, columns: incoming class
  function automatic prec_e prec_lookup(cls_e row, cls_e col);
    prec_e r;
    r = PR_ERR;
    unique case (row)
      CL_ADD: begin
        case (col)
          CL_MUL, CL_EXP, CL_LPAR: r = PR_PUSH;
          default:                 r = PR_REDUCE;
        endcase
      end
      CL_MUL, CL_EXP: begin
        case (col)
          CL_EXP, CL_LPAR: r = PR_PUSH;
          default:         r = PR_REDUCE;
        endcase
      end
      CL_LPAR: begin
        case (col)
          CL_RPAR: r = PR_POP;
          CL_END:  r = PR_ERR;
          default: r = PR_PUSH;
        endcase
      end
      CL_RPAR: begin
        case (col)
          CL_LPAR: r = PR_ERR;
          default: r = PR_REDUCE;
        endcase
      end
      default: begin
        case (col)
          CL_RPAR: r = PR_ERR;
          CL_END:  r = PR_POP;
          default: r = PR_PUSH;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/iee_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_if
// Valid/ready channels of the evaluator: character input and result output.
// ----------------------------------------------------------------------------
interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface iee_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         result_status;

  modport source (output valid, output result_value, output result_status, input ready);
  modport sink   (input valid, input result_value, input result_status, output ready);
endinterface

// File: design/iee_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/iee_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_alu
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module iee_alu #(
  parameter int WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iee_pkg::alu_req_t   req_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [WIDTH-1:0]    b_i,
  output logic                done_o,
  output logic [WIDTH-1:0]    acc_o,
  output logic [WIDTH-1:0]    quo_o
);
  import iee_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  alu_op_e          op_q, op_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH:0]   rem_t;
  logic [WIDTH:0]   diff;
  logic             ge;

  // one restoring divide step
  assign rem_t = {acc_q, x_q[WIDTH-1]};
  assign diff  = rem_t - {1'b0, y_q};
  assign ge    = ~diff[WIDTH];

  // iteration control and datapath
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = req_i.op;
      x_d    = a_i;
      y_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = x_q << 1;
        y_d = y_q >> 1;
      end else begin
        acc_d = ge ? diff[WIDTH-1:0] : rem_t[WIDTH-1:0];
        x_d   = {x_q[WIDTH-2:0], ge};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    op_q  <= op_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;
  assign quo_o  = x_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("alu started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("alu done without a running operation");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("alu done while still busy");

endmodule

// File: design/infix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Character-serial infix evaluator with operand and operator stacks.
// ----------------------------------------------------------------------------
// Takes one character per beat and returns one result beat per newline. A digit
// or unary minus is taken in the idle state. An operator is compared against
// the stack top in S_EVAL and may trigger reductions in S_RED, and a ')' that
// closes its '(' also passes through S_RDOP; a newline then passes through
// S_EMIT for the result beat. A reduction for '*', '/' or '%' waits on the
// bit-serial multiply/divide unit, and '^' runs square-and-multiply on that unit:
// one check per exponent bit plus up to two multiplications, and one final
// check. The input is not ready while a character is being worked on.
// The result sits in an output register, so the next line can start while it
// waits; a newline waits only if that register is still full. Both stacks
// live in RAMs with their top entries in registers; no clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_unit #(
  parameter int OPERAND_DEPTH  = 32,
  parameter int OPERATOR_DEPTH = 32,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  iee_char_if.sink  char_i,
  iee_res_if.source res_o
);
  import iee_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int DCW = $clog2(OPERAND_DEPTH + 1);
  localparam int DAW = $clog2(OPERAND_DEPTH);
  localparam int RCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int RAW = $clog2(OPERATOR_DEPTH);

  state_e         state_q, state_d;
  logic [DCW-1:0] opnd_cnt_q, opnd_cnt_d;
  logic [RCW-1:0] oprt_cnt_q, oprt_cnt_d;
  logic [W-1:0]   opd_top_q, opd_top_d;
  opc_t           op_top_q, op_top_d;
  logic [W-1:0]   acc_q, acc_d;
  logic           dig_q, dig_d;
  logic           neg_q, neg_d;
  logic [7:0]     prev_q, prev_d;
  status_e        lst_q, lst_d;
  logic [7:0]     c_q, c_d;
  opc_t           op_q, op_d;
  status_e        pend_q, pend_d;
  logic           a_neg_q, a_neg_d;
  logic [W-1:0]   pw_r_q, pw_r_d;
  logic [W-1:0]   pw_q_q, pw_q_d;
  logic [W-1:0]   pw_e_q, pw_e_d;
  logic           res_valid_q, res_valid_d;
  logic [31:0]    res_value_q, res_value_d;
  status_e        res_status_q, res_status_d;

  // stack RAM ports
  logic           od_we, od_re;
  logic [DAW-1:0] od_waddr, od_raddr;
  logic [W-1:0]   od_wdata, od_rdata;
  logic           or_we, or_re;
  logic [RAW-1:0] or_waddr, or_raddr;
  opc_t           or_wdata, or_rdata;

  // shared arithmetic unit
  alu_req_t       alu_req;
  logic [W-1:0]   alu_a, alu_b, alu_acc, alu_quo;
  logic           alu_done;

  // decode
  chr_t           in_chr, prev_chr, cur_chr;
  logic           accept, in_nl, in_skip, in_uminus, in_digit, in_paren_err;
  logic           prev_digit;
  logic signed [8:0] dig_val;
  logic [W-1:0]   acc_next, flush_val;
  logic           opnd_full, oprt_full, opnd_few;
  logic [DCW-1:0] opnd_m1, opnd_m2;
  logic [RCW-1:0] oprt_m1, oprt_m2;
  logic           cur_nl, eval_end, out_free;
  cls_e           cur_cls;
  prec_e          prec_r;
  status_e        red_st;
  logic [W-1:0]   a_mag, b_mag, quo_fix, rem_fix;

  assign char_i.ready = (state_q == S_IDLE);
  assign accept       = char_i.valid && char_i.ready;
  assign out_free     = !res_valid_q || res_o.ready;

  // input character classification
  assign in_chr       = char_decode(char_i.char_code);
  assign prev_chr     = char_decode(prev_q);
  assign in_nl        = (char_i.char_code == CH_NL);
  assign in_skip      = (lst_q != ST_OK);
  assign in_uminus    = (char_i.char_code == CH_MINUS) && (prev_chr.is_op || prev_q == CH_NL);
  assign in_digit     = !in_nl && !in_chr.is_op && !in_chr.is_rpar;
  assign prev_digit   = (prev_q >= CH_ZERO) && (prev_q <= CH_NINE);
  assign in_paren_err = (char_i.char_code == CH_LPAR) && prev_digit;

  // digit accumulation and number flush
  assign dig_val   = $signed({1'b0, char_i.char_code}) - 9'sd48;
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + W'(dig_val);
  assign flush_val = neg_q ? ('0 - acc_q) : acc_q;

  // stack bounds
  assign opnd_full = (opnd_cnt_q >= DCW'(OPERAND_DEPTH));
  assign oprt_full = (oprt_cnt_q >= RCW'(OPERATOR_DEPTH));
  assign opnd_few  = (opnd_cnt_q < DCW'(2));
  assign opnd_m1   = opnd_cnt_q - DCW'(1);
  assign opnd_m2   = opnd_cnt_q - DCW'(2);
  assign oprt_m1   = oprt_cnt_q - RCW'(1);
  assign oprt_m2   = oprt_cnt_q - RCW'(2);

  // precedence of the pending operator against the stack top
  assign cur_chr  = char_decode(c_q);
  assign cur_nl   = (c_q == CH_NL);
  assign cur_cls  = cur_nl ? CL_END : (cur_chr.is_rpar ? CL_RPAR : op_class(cur_chr.code));
  assign prec_r   = prec_lookup(op_class(op_top_q), cur_cls);
  assign eval_end = cur_nl && (op_top_q == OPC_MARK);

  // reduction checks and sign handling
  assign a_mag   = od_rdata[W-1] ? ('0 - od_rdata) : od_rdata;
  assign b_mag   = opd_top_q[W-1] ? ('0 - opd_top_q) : opd_top_q;
  assign quo_fix = (a_neg_q ^ opd_top_q[W-1]) ? ('0 - alu_quo) : alu_quo;
  assign rem_fix = a_neg_q ? ('0 - alu_acc) : alu_acc;

  always_comb begin
    red_st = ST_OK;
    case (op_q)
      OPC_ADD, OPC_SUB, OPC_MUL: red_st = ST_OK;
      OPC_DIV, OPC_MOD:          red_st = (opd_top_q == '0) ? ST_DIVZERO : ST_OK;
      OPC_POW:                   red_st = opd_top_q[W-1] ? ST_SYNTAX : ST_OK;
      default:                   red_st = ST_SYNTAX;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_skip) begin
            if (in_nl) state_d = S_EMIT;
          end else if (!in_uminus && !in_digit && !in_paren_err) begin
            if (dig_q && opnd_full) state_d = in_nl ? S_EMIT : S_IDLE;
            else                    state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (eval_end) begin
          state_d = S_EMIT;
        end else begin
          unique case (prec_r)
            PR_PUSH:   state_d = (oprt_full && cur_nl) ? S_EMIT : S_IDLE;
            PR_POP:    state_d = S_RDOP;
            PR_REDUCE: state_d = opnd_few ? (cur_nl ? S_EMIT : S_IDLE) : S_RED;
            default:   state_d = cur_nl ? S_EMIT : S_IDLE;
          endcase
        end
      end
      S_RDOP: state_d = S_IDLE;
      S_RED: begin
        if (red_st != ST_OK) begin
          state_d = cur_nl ? S_EMIT : S_IDLE;
        end else begin
          case (op_q)
            OPC_MUL:          state_d = S_MUL;
            OPC_DIV, OPC_MOD: state_d = S_DIV;
            OPC_POW:          state_d = S_PW_CHK;
            default:          state_d = S_EVAL;
          endcase
        end
      end
      S_MUL, S_DIV: if (alu_done) state_d = S_EVAL;
      S_PW_CHK: begin
        if (pw_e_q == '0)   state_d = S_EVAL;
        else if (pw_e_q[0]) state_d = S_PW_MR;
        else                state_d = S_PW_MQ;
      end
      S_PW_MR: if (alu_done) state_d = S_PW_MQ;
      S_PW_MQ: if (alu_done) state_d = S_PW_CHK;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, stack ports and result register
  always_comb begin
    opnd_cnt_d   = opnd_cnt_q;
    oprt_cnt_d   = oprt_cnt_q;
    opd_top_d    = opd_top_q;
    op_top_d     = op_top_q;
    acc_d        = acc_q;
    dig_d        = dig_q;
    neg_d        = neg_q;
    prev_d       = prev_q;
    lst_d        = lst_q;
    c_d          = c_q;
    op_d         = op_q;
    pend_d       = pend_q;
    a_neg_d      = a_neg_q;
    pw_r_d       = pw_r_q;
    pw_q_d       = pw_q_q;
    pw_e_d       = pw_e_q;
    res_valid_d  = res_valid_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    od_we        = 1'b0;
    od_waddr     = opnd_m1[DAW-1:0];
    od_wdata     = opd_top_q;
    od_re        = 1'b0;
    od_raddr     = opnd_m2[DAW-1:0];
    or_we        = 1'b0;
    or_waddr     = oprt_m1[RAW-1:0];
    or_wdata     = op_top_q;
    or_re        = 1'b0;
    or_raddr     = oprt_m2[RAW-1:0];
    alu_req      = '{start: 1'b0, op: ALU_MUL};
    alu_a        = od_rdata;
    alu_b        = opd_top_q;

    // result beat taken
    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_skip) begin
            if (in_nl) pend_d = lst_q;
          end else if (in_uminus) begin
            neg_d  = 1'b1;
            prev_d = char_i.char_code;
          end else if (in_digit) begin
            acc_d  = acc_next;
            dig_d  = 1'b1;
            prev_d = char_i.char_code;
          end else if (in_paren_err) begin
            lst_d = ST_SYNTAX;
          end else begin
            c_d = char_i.char_code;
            if (dig_q) begin
              dig_d = 1'b0;
              neg_d = 1'b0;
              acc_d = '0;
              if (opnd_full) begin
                if (in_nl) pend_d = ST_SYNTAX;
                else       lst_d  = ST_SYNTAX;
              end else begin
                od_we      = (opnd_cnt_q != '0);
                opd_top_d  = flush_val;
                opnd_cnt_d = opnd_cnt_q + DCW'(1);
              end
            end
          end
        end
      end
      S_EVAL: begin
        if (eval_end) begin
          pend_d = (opnd_cnt_q == DCW'(1) && oprt_cnt_q == RCW'(1)) ? ST_OK : ST_SYNTAX;
        end else begin
          unique case (prec_r)
            PR_PUSH: begin
              if (oprt_full) begin
                if (cur_nl) pend_d = ST_SYNTAX;
                else        lst_d  = ST_SYNTAX;
              end else begin
                or_we      = 1'b1;
                op_top_d   = cur_chr.code;
                oprt_cnt_d = oprt_cnt_q + RCW'(1);
                prev_d     = c_q;
              end
            end
            PR_POP: begin
              or_re      = 1'b1;
              oprt_cnt_d = oprt_m1;
              prev_d     = c_q;
            end
            PR_REDUCE: begin
              if (opnd_few) begin
                if (cur_nl) pend_d = ST_SYNTAX;
                else        lst_d  = ST_SYNTAX;
              end else begin
                od_re      = 1'b1;
                or_re      = 1'b1;
                op_d       = op_top_q;
                oprt_cnt_d = oprt_m1;
                opnd_cnt_d = opnd_m1;
              end
            end
            default: begin
              if (cur_nl) pend_d = ST_SYNTAX;
              else        lst_d  = ST_SYNTAX;
            end
          endcase
        end
      end
      S_RDOP: op_top_d = or_rdata;
      S_RED: begin
        op_top_d = or_rdata;
        if (red_st != ST_OK) begin
          if (cur_nl) pend_d = red_st;
          else        lst_d  = red_st;
        end else begin
          case (op_q)
            OPC_ADD: opd_top_d = od_rdata + opd_top_q;
            OPC_SUB: opd_top_d = od_rdata - opd_top_q;
            OPC_MUL: alu_req = '{start: 1'b1, op: ALU_MUL};
            OPC_DIV, OPC_MOD: begin
              alu_req = '{start: 1'b1, op: ALU_DIV};
              alu_a   = a_mag;
              alu_b   = b_mag;
              a_neg_d = od_rdata[W-1];
            end
            OPC_POW: begin
              pw_r_d = W'(1);
              pw_q_d = od_rdata;
              pw_e_d = opd_top_q;
            end
            default: ;
          endcase
        end
      end
      S_MUL: if (alu_done) opd_top_d = alu_acc;
      S_DIV: if (alu_done) opd_top_d = (op_q == OPC_DIV) ? quo_fix : rem_fix;
      S_PW_CHK: begin
        if (pw_e_q == '0) begin
          opd_top_d = pw_r_q;
        end else begin
          alu_req = '{start: 1'b1, op: ALU_MUL};
          alu_a   = pw_e_q[0] ? pw_r_q : pw_q_q;
          alu_b   = pw_q_q;
        end
      end
      S_PW_MR: begin
        if (alu_done) begin
          pw_r_d  = alu_acc;
          alu_req = '{start: 1'b1, op: ALU_MUL};
          alu_a   = pw_q_q;
          alu_b   = pw_q_q;
        end
      end
      S_PW_MQ: begin
        if (alu_done) begin
          pw_q_d = alu_acc;
          pw_e_d = pw_e_q >> 1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_status_d = pend_q;
          res_value_d  = (pend_q == ST_OK) ? 32'($signed(opd_top_q)) : '0;
          // line reset
          opnd_cnt_d   = '0;
          oprt_cnt_d   = RCW'(1);
          op_top_d     = OPC_MARK;
          acc_d        = '0;
          dig_d        = 1'b0;
          neg_d        = 1'b0;
          prev_d       = CH_NL;
          lst_d        = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opnd_cnt_q  <= '0;
      oprt_cnt_q  <= RCW'(1);
      op_top_q    <= OPC_MARK;
      acc_q       <= '0;
      dig_q       <= 1'b0;
      neg_q       <= 1'b0;
      prev_q      <= CH_NL;
      lst_q       <= ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      opnd_cnt_q  <= opnd_cnt_d;
      oprt_cnt_q  <= oprt_cnt_d;
      op_top_q    <= op_top_d;
      acc_q       <= acc_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
      prev_q      <= prev_d;
      lst_q       <= lst_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    opd_top_q    <= opd_top_d;
    c_q          <= c_d;
    op_q         <= op_d;
    pend_q       <= pend_d;
    a_neg_q      <= a_neg_d;
    pw_r_q       <= pw_r_d;
    pw_q_q       <= pw_q_d;
    pw_e_q       <= pw_e_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  iee_ram #(.WIDTH(W), .DEPTH(OPERAND_DEPTH)) u_opnd_ram (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .re_i    (od_re),
    .raddr_i (od_raddr),
    .rdata_o (od_rdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_oprt_ram (
    .clk_i   (clk_i),
    .we_i    (or_we),
    .waddr_i (or_waddr),
    .wdata_i (or_wdata),
    .re_i    (or_re),
    .raddr_i (or_raddr),
    .rdata_o (or_rdata)
  );

  iee_alu #(.WIDTH(W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .acc_o  (alu_acc),
    .quo_o  (alu_quo)
  );

  assign res_o.valid         = res_valid_q;
  assign res_o.result_value  = res_value_q;
  assign res_o.result_status = res_status_q;

  a_opnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opnd_cnt_q <= DCW'(OPERAND_DEPTH))
    else $error("operand count beyond depth");

  a_oprt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oprt_cnt_q >= RCW'(1) && oprt_cnt_q <= RCW'(OPERATOR_DEPTH))
    else $error("operator count out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_status_q != ST_OK |-> res_value_q == '0)
    else $error("error beat with nonzero value");

  a_alu_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q == S_MUL || state_q == S_DIV || state_q == S_PW_MR
                 || state_q == S_PW_MQ)
    else $error("alu finished outside a wait state");

endmodule
